/* sv/utf8_to_utf16_converter_top_assert.svh */
// Assertion macros for the UTF-8 to UTF-16 converter.
// Used by utf8_to_utf16_converter_top; no other dependencies.
`ifndef UTF8_TO_UTF16_CONVERTER_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define U8U16_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");
`else
`define U8U16_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/u8u16_pkg.sv */
// Types and constants for the UTF-8 to UTF-16 converter.
// No dependencies; used by u8u16_dec and utf8_to_utf16_converter_top.
package u8u16_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [15:0] unit_value;
        logic        unit_valid;
        logic [2:0]  error_code;
    } t_out_item;

    localparam logic       ACT_DATA = 1'b0;
    localparam logic       ACT_END  = 1'b1;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ERR_BAD_SECOND = 3'd2;
    localparam logic [2:0] ERR_BAD_THIRD = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    localparam logic [2:0] LEAD_TWO   = 3'b110;
    localparam logic [2:0] LEAD_THREE = 3'b111;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    localparam logic [15:0] BOM_NATIVE  = 16'hFEFF;
    localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

/* sv/u8u16_dec.sv */
// Symbol decoder: running symbol state, BOM detection and unit assembly.
// Depends on u8u16_pkg.
module u8u16_dec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  u8u16_pkg::t_in_item  i_item,
    output logic                 o_emit,
    output u8u16_pkg::t_out_item o_res
);
    import u8u16_pkg::*;

    logic [15:0] r_partial, n_partial;
    logic [1:0]  r_len, n_len;
    logic [1:0]  r_seen, n_seen;
    logic        r_await, n_await;
    logic        r_swap, n_swap;

    logic        fin;
    logic [15:0] fin_val;
    logic [2:0]  fin_err;
    logic        trunc;
    logic [7:0]  b;

    always_comb begin
        b         = i_item.data_byte;
        n_partial = r_partial;
        n_len     = r_len;
        n_seen    = r_seen;
        n_await   = r_await;
        n_swap    = r_swap;
        fin       = 1'b0;
        fin_val   = '0;
        fin_err   = ERR_NONE;
        trunc     = 1'b0;
        o_emit    = 1'b0;
        o_res     = '0;

        if (i_item.action == ACT_END) begin
            trunc     = (r_len != LEN_NONE);
            n_partial = '0;
            n_len     = LEN_NONE;
            n_seen    = SEEN_NONE;
            n_await   = 1'b1;
            n_swap    = 1'b0;
        end else if (r_len == LEN_NONE) begin
            if (!b[7]) begin
                fin     = 1'b1;
                fin_val = {8'd0, b};
            end else if (b[7:5] == LEAD_TWO) begin
                n_partial = {5'd0, b[4:0], 6'd0};
                n_len     = LEN_TWO;
                n_seen    = SEEN_ONE;
            end else if (b[7:5] == LEAD_THREE) begin
                n_partial = {b[3:0], 12'd0};
                n_len     = LEN_THREE;
                n_seen    = SEEN_ONE;
            end else begin
                fin     = 1'b1;
                fin_err = ERR_BAD_LEAD;
            end
        end else if (b[7:6] == CONT_TAG) begin
            if (r_len == LEN_TWO || r_seen[1]) begin
                fin     = 1'b1;
                fin_val = r_partial | {10'd0, b[5:0]};
            end else begin
                n_partial = r_partial | {4'd0, b[5:0], 6'd0};
                n_seen    = SEEN_TWO;
            end
        end else begin
            fin     = 1'b1;
            fin_val = r_partial;
            fin_err = (r_seen == SEEN_ONE) ? ERR_BAD_SECOND : ERR_BAD_THIRD;
        end

        if (trunc) begin
            o_emit           = 1'b1;
            o_res.error_code = ERR_TRUNC;
        end else if (fin) begin
            n_partial = '0;
            n_len     = LEN_NONE;
            n_seen    = SEEN_NONE;
            if (r_await) begin
                n_await = 1'b0;
                if (fin_val == BOM_NATIVE) begin
                    n_swap = 1'b0;
                end else if (fin_val == BOM_SWAPPED) begin
                    n_swap = 1'b1;
                end else begin
                    o_emit = 1'b1;
                    o_res  = '{unit_value: fin_val, unit_valid: 1'b1, error_code: fin_err};
                end
            end else begin
                o_emit = 1'b1;
                o_res  = '{unit_value: r_swap ? swap16(fin_val) : fin_val,
                           unit_valid: 1'b1, error_code: fin_err};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_len     <= LEN_NONE;
            r_seen    <= SEEN_NONE;
            r_await   <= 1'b1;
            r_swap    <= 1'b0;
        end else if (i_fire) begin
            r_partial <= n_partial;
            r_len     <= n_len;
            r_seen    <= n_seen;
            r_await   <= n_await;
            r_swap    <= n_swap;
        end
    end

endmodule

/* sv/utf8_to_utf16_converter_top.sv */
// UTF-8 to UTF-16 converter: input register, decoder, output register.
// Depends on u8u16_pkg, u8u16_dec and utf8_to_utf16_converter_top_assert.svh.
// Each accepted beat waits in the input register and is decoded combinationally; its result
// enters the output register when the beat advances, which an output stall can hold off.
// Throughput: one byte per cycle while the output is not stalled; the decoder next-state logic is combinational.
// Reset (synchronous, active low) empties both registers and reopens the BOM check.
module utf8_to_utf16_converter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  u8u16_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output u8u16_pkg::t_out_item o_out_item
);
    import u8u16_pkg::*;
    `include "utf8_to_utf16_converter_top_assert.svh"

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;
    logic      dec_emit;
    t_out_item dec_res;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    u8u16_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (r_in_item),
        .o_emit  (dec_emit),
        .o_res   (dec_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && dec_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_emit) begin
            r_out_item <= dec_res;
        end
    end

    `U8U16_ASSERT_SAME(a_trunc_no_unit, i_clk, i_rst_n,
        r_out_valid && (r_out_item.error_code == ERR_TRUNC),
        !r_out_item.unit_valid && (r_out_item.unit_value == 16'd0))
    `U8U16_ASSERT_SAME(a_invalid_is_trunc, i_clk, i_rst_n,
        r_out_valid && !r_out_item.unit_valid, r_out_item.error_code == ERR_TRUNC)
    `U8U16_ASSERT_SAME(a_err_range, i_clk, i_rst_n,
        r_out_valid, r_out_item.error_code <= ERR_TRUNC)
    `U8U16_ASSERT_NEXT(a_in_held, i_clk, i_rst_n,
        r_in_valid && !advance, r_in_valid && $stable(r_in_item))

endmodule

/* verif/u8u16_unit_checker.sv */
`timescale 1ns / 100ps
// Checker for utf8_to_utf16_converter_top: watches both channels, predicts each unit.
// Depends on u8u16_pkg; instantiated by utf8_to_utf16_converter_top_test.
module u8u16_unit_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  u8u16_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  u8u16_pkg::t_out_item i_out_item,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_units_checked
);
    import u8u16_pkg::*;

    t_out_item   expected_units[$];
    logic [15:0] acc_bits;
    logic [1:0]  open_len;
    logic [1:0]  seen_cnt;
    logic        bom_check;
    logic        swap_on;
    int          mismatches = 0;
    int          checked = 0;

    task automatic clear_stream();
        acc_bits = '0;
        open_len = LEN_NONE;
        seen_cnt = SEEN_NONE;
        bom_check = 1'b1;
        swap_on = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic close_symbol(input logic [15:0] v, input logic [2:0] err);
        t_out_item r;
        acc_bits = '0;
        open_len = LEN_NONE;
        seen_cnt = SEEN_NONE;
        if (bom_check) begin
            bom_check = 1'b0;
            if (v == BOM_NATIVE) begin
                swap_on = 1'b0;
                return;
            end
            if (v == BOM_SWAPPED) begin
                swap_on = 1'b1;
                return;
            end
            r.unit_value = v;
        end else begin
            r.unit_value = swap_on ? {v[7:0], v[15:8]} : v;
        end
        r.unit_valid = 1'b1;
        r.error_code = err;
        expected_units.push_back(r);
    endtask

    task automatic decode_beat(input t_in_item it);
        logic [7:0] b;
        t_out_item  r;
        b = it.data_byte;
        if (it.action == ACT_END) begin
            if (open_len != LEN_NONE) begin
                r.unit_value = '0;
                r.unit_valid = 1'b0;
                r.error_code = ERR_TRUNC;
                expected_units.push_back(r);
            end
            clear_stream();
        end else if (open_len == LEN_NONE) begin
            if (!b[7]) begin
                close_symbol({8'h00, b}, ERR_NONE);
            end else if (b[7:5] == LEAD_TWO) begin
                acc_bits = {5'd0, b[4:0], 6'd0};
                open_len = LEN_TWO;
                seen_cnt = SEEN_ONE;
            end else if (b[7:5] == LEAD_THREE) begin
                acc_bits = {b[3:0], 12'd0};
                open_len = LEN_THREE;
                seen_cnt = SEEN_ONE;
            end else begin
                close_symbol(16'h0000, ERR_BAD_LEAD);
            end
        end else if (b[7:6] == CONT_TAG) begin
            if (open_len == LEN_TWO || seen_cnt == SEEN_TWO) begin
                close_symbol(acc_bits | {10'd0, b[5:0]}, ERR_NONE);
            end else begin
                acc_bits = acc_bits | {4'd0, b[5:0], 6'd0};
                seen_cnt = SEEN_TWO;
            end
        end else begin
            close_symbol(acc_bits, (seen_cnt == SEEN_ONE) ? ERR_BAD_SECOND : ERR_BAD_THIRD);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            clear_stream();
            expected_units.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_units.size() == 0) begin
                    report_mismatch($sformatf("unexpected unit %h valid %b err %0d",
                        i_out_item.unit_value, i_out_item.unit_valid,
                        i_out_item.error_code));
                end else begin
                    e = expected_units.pop_front();
                    if (i_out_item.unit_value !== e.unit_value)
                        report_mismatch($sformatf("unit_value %h, expected %h",
                            i_out_item.unit_value, e.unit_value));
                    if (i_out_item.unit_valid !== e.unit_valid)
                        report_mismatch($sformatf("unit_valid %b, expected %b",
                            i_out_item.unit_valid, e.unit_valid));
                    if (i_out_item.error_code !== e.error_code)
                        report_mismatch($sformatf("error_code %0d, expected %0d",
                            i_out_item.error_code, e.error_code));
                end
            end
            if (i_in_valid && !i_in_stall)
                decode_beat(i_in_item);
        end
        o_fail_count <= mismatches;
        o_pending <= expected_units.size();
        o_units_checked <= checked;
    end

endmodule

/* verif/utf8_to_utf16_converter_top_test.sv */
`timescale 1ns / 100ps
// Testbench top for utf8_to_utf16_converter_top: clock, reset, byte stimulus, verdict.
// Depends on u8u16_pkg, the converter RTL and u8u16_unit_checker.
module utf8_to_utf16_converter_top_test;
    import u8u16_pkg::*;

    localparam int BEAT_TARGET  = 1350;
    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int idle_pct = 0;
    int stall_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int beats_sent = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;
    int units_checked;

    always #4 i_clk = ~i_clk;

    utf8_to_utf16_converter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    u8u16_unit_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (o_in_stall),
        .i_in_item       (in_item),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .i_out_item      (o_out_item),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_units_checked (units_checked)
    );

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[utf8_to_utf16_converter_top] ERROR");
            $finish;
        end
    end

    task automatic send_beat(input logic act, input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item.action <= act;
        in_item.data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(ACT_DATA, b);
    endtask

    task automatic send_cont();
        logic [31:0] rnd;
        rnd = $urandom;
        send_byte({CONT_TAG, rnd[5:0]});
    endtask

    task automatic send_non_cont();
        logic [31:0] rnd;
        logic [7:0]  b;
        rnd = $urandom;
        b = rnd[7:0];
        if (b[7:6] == CONT_TAG)
            b[7] = ~b[7];
        send_byte(b);
    endtask

    task automatic send_lead(input logic three);
        logic [31:0] rnd;
        rnd = $urandom;
        if (three)
            send_byte({LEAD_THREE, rnd[4:0]});
        else
            send_byte({LEAD_TWO, rnd[4:0]});
    endtask

    initial begin
        int          kind;
        int          nsym;
        logic [31:0] rnd;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // native BOM dropped, then ASCII
        send_byte(8'hEF); send_byte(8'hBB); send_byte(8'hBF);
        send_byte(8'h41); send_beat(ACT_END, 8'hFF);
        // swapped BOM, later units byte-swapped
        send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBE);
        send_byte(8'hC3); send_byte(8'hA9); send_byte(8'h7F);
        send_beat(ACT_END, 8'h00);
        // bad lead as first symbol, then bad second / third bytes
        send_byte(8'h80); send_byte(8'h00);
        send_byte(8'hC2); send_byte(8'h41);
        send_byte(8'hFF); send_byte(8'hBF); send_byte(8'hC0);
        send_byte(8'hDF); send_byte(8'hBF);
        send_byte(8'hE0); send_byte(8'h80); send_byte(8'h80);
        // truncated symbol, then end with nothing open
        send_byte(8'hE5); send_byte(8'h81); send_beat(ACT_END, 8'h5A);
        send_beat(ACT_END, 8'hA5);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_seq <= hold_seq + 1;
                end
                1: begin
                    idle_pct = 51;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;
                    stall_pct <= 51;
                end
                default: begin
                    idle_pct = 7;
                    stall_pct <= 7;
                end
            endcase
            while (beats_sent < BEAT_TARGET * (ph + 1) / 4) begin
                kind = $urandom_range(99);
                if (kind < 30) begin
                    send_byte(8'hEF); send_byte(8'hBB); send_byte(8'hBF);
                end else if (kind < 50) begin
                    send_byte(8'hEF); send_byte(8'hBF); send_byte(8'hBE);
                end
                nsym = $urandom_range(16, 1);
                repeat (nsym) begin
                    kind = $urandom_range(99);
                    rnd = $urandom;
                    if (kind < 35) begin
                        send_byte({1'b0, rnd[6:0]});
                    end else if (kind < 60) begin
                        send_lead(1'b0);
                        send_cont();
                    end else if (kind < 80) begin
                        send_lead(1'b1);
                        send_cont();
                        send_cont();
                    end else if (kind < 86) begin
                        send_byte({CONT_TAG, rnd[5:0]});
                    end else if (kind < 93) begin
                        send_lead(rnd[8]);
                        if (rnd[8] && rnd[9])
                            send_cont();
                        send_non_cont();
                    end else begin
                        send_byte(rnd[7:0]);
                    end
                end
                kind = $urandom_range(99);
                rnd = $urandom;
                if (kind < 15) begin
                    send_lead(rnd[8]);
                    if (rnd[8] && rnd[9])
                        send_cont();
                    send_beat(ACT_END, rnd[7:0]);
                end else if (kind < 80) begin
                    send_beat(ACT_END, rnd[7:0]);
                end
            end
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run: %0d beats through no-idle, sender-idle, receiver-stall, mixed phases",
            beats_sent);
        $display("and a %0d-cycle output hold-off; %0d units checked, %0d mismatches",
            HOLD_CYCLES, units_checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[utf8_to_utf16_converter_top] OK");
        end else begin
            $display("[utf8_to_utf16_converter_top] ERROR");
        end
        $finish;
    end

endmodule
